@@ sv/drtm_pkg.sv @@
// Package: item types, action codes and phase codes for the ramp timer.
`default_nettype none
package drtm_pkg;

    typedef enum logic [3:0] {
        ACT_TICK     = 4'd0,
        ACT_START    = 4'd1,
        ACT_STOP     = 4'd2,
        ACT_RESET    = 4'd3,
        ACT_GET      = 4'd4,
        ACT_ADD      = 4'd5,
        ACT_ONCE     = 4'd6,
        ACT_FLAG     = 4'd7,
        ACT_FRACTION = 4'd8
    } action_t;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_RAMP    = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    localparam logic [16:0] Q_ONE = 17'd65536;

    typedef struct packed {
        logic [3:0]         action;
        logic [31:0]        wait_ms;
        logic [31:0]        duration_ms;
        logic signed [15:0] start_value;
        logic signed [15:0] end_value;
        logic [3:0]         notify_index;
        logic [31:0]        elapse_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic [1:0]         status;
        logic               fired;
        logic               flag;
        logic               not_flag;
        logic [16:0]        fraction;
        logic               table_full;
    } out_item_t;

endpackage
`default_nettype wire

@@ sv/delayed_ramp_timer_with_markers.sv @@
// Top level: delayed ramp timer with marker table and a shared bit-serial divider.
`default_nettype none
// One item at a time; in ready is high only in the idle state, and the result
// register holds one item until taken. Control actions (tick, start, stop,
// reset, add marker) and marker queries go from idle straight to the output
// state: accepting the item loads the result register, which is handed over
// when out_ready is high. A value query on a running ramp first forms the
// product of the value span and the elapsed time with a shift-and-add
// multiplier that consumes one bit of the elapsed time per cycle. It then
// divides that product by the duration in a restoring divider that retires one
// quotient bit per cycle over 48 bits, and loads the result in the done state.
// A segment-fraction query that needs a divide skips the multiplier and
// divides the elapsed time shifted up by 16 by the segment length. The result
// waits in the output state while out_ready stays low.
module delayed_ramp_timer_with_markers
    import drtm_pkg::*;
#(
    parameter int NOTIFY_SLOTS = 8
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    localparam int SW = $clog2(NOTIFY_SLOTS + 1);
    localparam int IW = (NOTIFY_SLOTS > 1) ? $clog2(NOTIFY_SLOTS) : 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_DIV  = 5'b00100,
        S_DONE = 5'b01000,
        S_OUT  = 5'b10000
    } fsm_t;

    fsm_t fsm_reg, fsm_next;

    // architectural state
    logic [31:0]        now_reg, start_reg, end_reg, dur_reg;
    logic signed [15:0] first_reg, last_reg;
    logic [1:0]         anim_reg;
    logic [31:0]        elapse_reg [NOTIFY_SLOTS];
    logic [NOTIFY_SLOTS-1:0] fired_reg;
    logic [SW-1:0]      count_reg;

    // datapath
    out_item_t          res_reg, res_next;
    logic               out_valid_reg;
    logic [47:0]        num_reg;     // dividend shifting out MSB first
    logic [31:0]        mcand_reg;   // multiplier operand (elapsed), shifts right
    logic [47:0]        prod_reg;
    logic [31:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [31:0]        den_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg;     // value query: ramp goes down
    logic               is_frac_reg;

    // index decode
    logic               idx_ok;
    logic [IW-1:0]      idx;
    logic [31:0]        seg_s, seg_m, seg_e, ramp_el;
    logic               mark_hit;
    logic [16:0]        span;
    logic signed [17:0] diff;
    logic               go_mul, go_div;

    assign idx    = in_data.notify_index[IW-1:0];
    assign idx_ok = {{(8-SW){1'b0}}, count_reg} > {4'd0, in_data.notify_index};
    assign seg_s  = (in_data.notify_index == 4'd0 || !idx_ok) ? start_reg
                  : elapse_reg[idx - IW'(1)] + start_reg;
    assign seg_m  = elapse_reg[idx] + start_reg - seg_s;
    assign seg_e  = now_reg - seg_s;
    assign ramp_el = now_reg - start_reg;
    assign mark_hit = idx_ok && (now_reg >= start_reg) && (anim_reg != ST_INVALID)
                    && (elapse_reg[idx] < ramp_el) && !fired_reg[idx];
    assign diff = 18'(last_reg) - 18'(first_reg);
    assign span = diff[17] ? 17'(-diff) : 17'(diff);

    // interpolate only while ramping with elapsed time inside the duration
    assign go_mul = (in_data.action == ACT_GET) && (anim_reg != ST_INVALID)
                  && !(now_reg < start_reg) && (now_reg <= end_reg)
                  && !(dur_reg == 32'd0 || ramp_el >= dur_reg);
    // divide only inside a segment of nonzero length
    assign go_div = (in_data.action == ACT_FRACTION) && idx_ok && (now_reg >= seg_s)
                  && (seg_m != 32'd0) && (seg_e < seg_m);

    assign in_ready  = (fsm_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    // one restoring step
    logic [32:0] trial;
    logic [32:0] rem_sh;
    assign rem_sh = {rem_reg, num_reg[47]};
    assign trial  = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        fsm_next = fsm_reg;
        res_next = res_reg;
        case (fsm_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (go_mul)
                        fsm_next = S_MUL;
                    else if (go_div)
                        fsm_next = S_DIV;
                    else
                        fsm_next = S_OUT;
                    res_next = '0;
                    case (in_data.action)
                        ACT_GET:
                        begin
                            if (anim_reg != ST_INVALID)
                            begin
                                if (now_reg < start_reg)
                                begin
                                    res_next.status = ST_WAIT;
                                    res_next.value  = first_reg;
                                end
                                else if (now_reg <= end_reg)
                                begin
                                    // end value unless the divider replaces it
                                    res_next.status = ST_RAMP;
                                    res_next.value  = last_reg;
                                end
                                else
                                begin
                                    res_next.status = ST_FINISH;
                                    res_next.value  = last_reg;
                                end
                            end
                        end
                        ACT_ADD:
                            res_next.table_full = (count_reg == SW'(NOTIFY_SLOTS));
                        ACT_ONCE:
                            res_next.fired = mark_hit;
                        ACT_FLAG:
                        begin
                            if (anim_reg != ST_INVALID && idx_ok)
                            begin
                                res_next.flag     = mark_hit | fired_reg[idx];
                                res_next.not_flag = !(mark_hit | fired_reg[idx]);
                            end
                        end
                        ACT_FRACTION:
                        begin
                            if (idx_ok && now_reg >= seg_s)
                                res_next.fraction = Q_ONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_MUL:    if (cnt_reg == 6'd31) fsm_next = S_DIV;
            S_DIV:    if (cnt_reg == 6'd47) fsm_next = S_DONE;
            S_DONE:
            begin
                fsm_next = S_OUT;
                if (is_frac_reg)
                    res_next.fraction = quo_reg;
                else if (neg_reg)
                    res_next.value = 16'(first_reg - $signed(quo_reg[15:0]));
                else
                    res_next.value = 16'(first_reg + $signed(quo_reg[15:0]));
            end
            S_OUT:    if (out_valid_reg && out_ready) fsm_next = S_IDLE;
            default:  fsm_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
            now_reg       <= '0;
            start_reg     <= '0;
            end_reg       <= '0;
            dur_reg       <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            anim_reg      <= ST_INVALID;
            fired_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= (fsm_next == S_OUT);
            if (fsm_reg == S_IDLE && in_valid)
            begin
                case (in_data.action)
                    ACT_TICK:  now_reg <= now_reg + 32'd1;
                    ACT_START:
                    begin
                        start_reg <= now_reg + in_data.wait_ms;
                        end_reg   <= now_reg + in_data.wait_ms + in_data.duration_ms;
                        dur_reg   <= in_data.duration_ms;
                        first_reg <= in_data.start_value;
                        last_reg  <= in_data.end_value;
                        anim_reg  <= ST_RAMP;
                    end
                    ACT_STOP:  end_reg <= now_reg;
                    ACT_RESET:
                    begin
                        start_reg <= '0;
                        anim_reg  <= ST_INVALID;
                        fired_reg <= '0;
                        count_reg <= '0;
                    end
                    ACT_GET:
                    begin
                        if (anim_reg != ST_INVALID)
                        begin
                            if (now_reg < start_reg)
                                anim_reg <= ST_WAIT;
                            else if (now_reg <= end_reg)
                                anim_reg <= ST_RAMP;
                            else
                                anim_reg <= ST_FINISH;
                        end
                    end
                    ACT_ADD:
                    begin
                        if (count_reg != SW'(NOTIFY_SLOTS))
                        begin
                            fired_reg[count_reg[IW-1:0]] <= 1'b0;
                            count_reg <= count_reg + SW'(1);
                        end
                    end
                    ACT_ONCE, ACT_FLAG:
                        if (mark_hit) fired_reg[idx] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // marker times, payload only
    always_ff @(posedge clk)
    begin
        if (fsm_reg == S_IDLE && in_valid && in_data.action == ACT_ADD
            && count_reg != SW'(NOTIFY_SLOTS))
            elapse_reg[count_reg[IW-1:0]] <= in_data.elapse_ms;
    end

    // result and serial arithmetic, payload only
    always_ff @(posedge clk)
    begin
        if (fsm_reg == S_IDLE && in_valid)
        begin
            res_reg     <= res_next;
            rem_reg     <= '0;
            quo_reg     <= '0;
            cnt_reg     <= '0;
            prod_reg    <= '0;
            mcand_reg   <= ramp_el;
            den_reg     <= (in_data.action == ACT_FRACTION) ? seg_m : dur_reg;
            neg_reg     <= diff[17];
            is_frac_reg <= (in_data.action == ACT_FRACTION);
            num_reg     <= {seg_e, 16'd0};
        end
        else if (fsm_reg == S_MUL)
        begin
            // shift-and-add: span times elapsed, one bit of elapsed per cycle
            if (mcand_reg[0])
                prod_reg <= prod_reg + ({31'd0, span} << cnt_reg[4:0]);
            mcand_reg <= mcand_reg >> 1;
            if (cnt_reg == 6'd31)
            begin
                cnt_reg <= '0;
                num_reg <= prod_reg + (mcand_reg[0] ? ({31'd0, span} << 5'd31) : 48'd0);
            end
            else
                cnt_reg <= cnt_reg + 6'd1;
        end
        else if (fsm_reg == S_DIV)
        begin
            // one quotient bit per cycle
            num_reg <= num_reg << 1;
            if (!trial[32])
                rem_reg <= trial[31:0];
            else
                rem_reg <= rem_sh[31:0];
            quo_reg <= {quo_reg[15:0], !trial[32]};
            cnt_reg <= cnt_reg + 6'd1;
        end
        else if (fsm_reg == S_DONE)
            res_reg <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_MUL || fsm_reg == S_DIV) |-> !in_ready && !out_valid)
        else $error("ready or valid while arithmetic busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(8-SW){1'b0}}, count_reg} <= 8'(NOTIFY_SLOTS))
        else $error("marker count above table size");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == S_DONE) |=> out_valid)
        else $error("result not presented after divide");
`endif

endmodule
`default_nettype wire
